@@ design/sst_pkg.sv @@
// Shared types, token codes and character helpers for the script source tokenizer.
// Used by sst_core, sst_obuf and script_source_tokenizer; depends on nothing.
package sst_pkg;

  // Token kinds
  localparam logic [5:0] K_PLUS     = 6'd21;
  localparam logic [5:0] K_MINUS    = 6'd22;
  localparam logic [5:0] K_TIMES    = 6'd23;
  localparam logic [5:0] K_DIVIDE   = 6'd24;
  localparam logic [5:0] K_MOD      = 6'd25;
  localparam logic [5:0] K_POW      = 6'd26;
  localparam logic [5:0] K_HASH     = 6'd27;
  localparam logic [5:0] K_EQ       = 6'd28;
  localparam logic [5:0] K_NE       = 6'd29;
  localparam logic [5:0] K_LE       = 6'd30;
  localparam logic [5:0] K_GE       = 6'd31;
  localparam logic [5:0] K_LT       = 6'd32;
  localparam logic [5:0] K_GT       = 6'd33;
  localparam logic [5:0] K_SET      = 6'd34;
  localparam logic [5:0] K_LPAREN   = 6'd35;
  localparam logic [5:0] K_RPAREN   = 6'd36;
  localparam logic [5:0] K_LBRACE   = 6'd37;
  localparam logic [5:0] K_RBRACE   = 6'd38;
  localparam logic [5:0] K_LBRACKET = 6'd39;
  localparam logic [5:0] K_RBRACKET = 6'd40;
  localparam logic [5:0] K_SEMI     = 6'd41;
  localparam logic [5:0] K_COLON    = 6'd42;
  localparam logic [5:0] K_COMMA    = 6'd43;
  localparam logic [5:0] K_DOT      = 6'd44;
  localparam logic [5:0] K_CONCAT   = 6'd45;
  localparam logic [5:0] K_DOTS     = 6'd46;
  localparam logic [5:0] K_NAME     = 6'd48;
  localparam logic [5:0] K_NUMBER   = 6'd49;
  localparam logic [5:0] K_STRING   = 6'd50;
  localparam logic [5:0] K_END      = 6'd51;
  localparam logic [5:0] K_OTHER    = 6'd52;

  // Error codes
  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_STRING  = 2'd1;
  localparam logic [1:0] E_LONG    = 2'd2;
  localparam logic [1:0] E_DELIM   = 2'd3;

  // Line end characters
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;
  localparam int unsigned KW_COUNT = 21;
  localparam int unsigned KW_CHARS = 8;

  // Keyword text, right-aligned: last character in the low byte
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    "and", "break", "do", "elseif", "else", "end", "false", "for", "function",
    "if", "in", "local", "nil", "not", "or", "repeat", "return", "then", "true",
    "until", "while"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd2, 4'd6, 4'd4, 4'd3, 4'd5, 4'd3, 4'd8,
    4'd2, 4'd2, 4'd5, 4'd3, 4'd3, 4'd2, 4'd6, 4'd6, 4'd4, 4'd4,
    4'd5, 4'd5
  };

  // Scan modes, one-hot
  typedef enum logic [23:0] {
    M_IDLE       = 24'h000001,
    M_MINUS      = 24'h000002,
    M_CMT_START  = 24'h000004,
    M_CMT_BRK    = 24'h000008,
    M_CMT_SHORT  = 24'h000010,
    M_CMT_BODY   = 24'h000020,
    M_CMT_CLOSE  = 24'h000040,
    M_BRK        = 24'h000080,
    M_LSTR_FIRST = 24'h000100,
    M_LSTR_BODY  = 24'h000200,
    M_LSTR_CLOSE = 24'h000400,
    M_EQ         = 24'h000800,
    M_LT         = 24'h001000,
    M_GT         = 24'h002000,
    M_TILDE      = 24'h004000,
    M_STR        = 24'h008000,
    M_SESC       = 24'h010000,
    M_SDEC       = 24'h020000,
    M_DOT        = 24'h040000,
    M_DOT2       = 24'h080000,
    M_NUM        = 24'h100000,
    M_NUMEXP     = 24'h200000,
    M_NUMTAIL    = 24'h400000,
    M_NAME       = 24'h800000
  } sst_mode_e;

  // One token as delivered on the result channel
  typedef struct packed {
    logic [5:0]  kind;
    logic [7:0]  raw;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic [1:0]  err;
    logic        last;
  } sst_res_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic is_word(logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == "_");
  endfunction

  function automatic logic is_nl(logic [7:0] b);
    return (b == CHAR_LF) || (b == CHAR_CR);
  endfunction

  // Saturating length add
  function automatic logic [15:0] add_sat(logic [15:0] a, logic [16:0] k);
    logic [17:0] s;
    s = {2'b00, a} + {1'b0, k};
    return (s > {2'b00, LEN_MAX}) ? LEN_MAX : s[15:0];
  endfunction

  // Keyword lookup; w holds character j at bits [8j+:8]
  function automatic logic [5:0] kw_kind(logic [63:0] w, logic [15:0] len);
    logic [5:0] k;
    logic       hit;
    k = K_NAME;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      hit = (len == 16'(KW_LEN[i]));
      for (int j = 0; j < KW_CHARS; j++) begin
        if ((j < int'(KW_LEN[i])) &&
            (w[8*j +: 8] != KW_TEXT[i][8*(int'(KW_LEN[i]) - 1 - j) +: 8])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        k = 6'(i);
      end
    end
    return k;
  endfunction

endpackage

@@ design/sst_core.sv @@
// Scanner state and the single-pass next-state and token logic for one source byte.
// Depends on sst_pkg.
module sst_core import sst_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16,
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned WORD_CHARS  = 8,
  parameter int unsigned LEVEL_BITS  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output sst_res_t   res0_o,
  output sst_res_t   res1_o,
  output logic [1:0] count_o
);

  localparam int unsigned IdxBits = $clog2(WORD_CHARS);

  sst_mode_e              mode_q, mode_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [OFFSET_BITS-1:0] ts_q, ts_d;
  logic [15:0]            tl_q, tl_d;
  logic [7:0]             pnl_q, pnl_d;
  logic [LEVEL_BITS-1:0]  ol_q, ol_d;
  logic [LEVEL_BITS-1:0]  cl_q, cl_d;
  logic [7:0]             qc_q, qc_d;
  logic [1:0]             ed_q, ed_d;
  logic [7:0]             wb_q [WORD_CHARS];

  logic                   wb_we;
  logic [IdxBits-1:0]     wb_idx;
  logic [7:0]             wb_ch;
  logic [63:0]            word;
  logic [OFFSET_BITS-1:0] pos, pos1;
  logic                   nl, rs, keep;
  logic                   do_close, do_body, do_str, do_scmt;
  logic                   p_en, i_en;
  sst_res_t               p_res, i_res;
  logic [5:0]             op_k;

  function automatic logic [LEVEL_BITS-1:0] lvl_inc(logic [LEVEL_BITS-1:0] v);
    return (v == '1) ? v : v + LEVEL_BITS'(1);
  endfunction

  function automatic sst_res_t mk(logic [5:0] k, logic [7:0] r, logic [15:0] s,
                                  logic [15:0] l, logic [15:0] ln, logic [1:0] e);
    sst_res_t t;
    t.kind  = k;
    t.raw   = r;
    t.start = s;
    t.len   = l;
    t.line  = ln;
    t.err   = e;
    t.last  = 1'b0;
    return t;
  endfunction

  // Gather the first keyword-length characters of the word buffer
  always_comb begin
    for (int j = 0; j < KW_CHARS; j++) begin
      word[8*j +: 8] = wb_q[j];
    end
  end

  // Next state and tokens for one byte
  always_comb begin
    mode_d  = mode_q;
    ts_d    = ts_q;
    tl_d    = tl_q;
    ol_d    = ol_q;
    cl_d    = cl_q;
    qc_d    = qc_q;
    ed_d    = ed_q;
    pnl_d   = pnl_q;
    line_d  = line_q;
    pos     = off_q;
    pos1    = off_q + OFFSET_BITS'(1);
    off_d   = pos1;
    nl      = is_nl(byte_i);
    rs      = 1'b0;
    keep    = 1'b0;
    do_close = 1'b0;
    do_body = 1'b0;
    do_str  = 1'b0;
    do_scmt = 1'b0;
    p_en    = 1'b0;
    i_en    = 1'b0;
    p_res   = '0;
    i_res   = '0;
    wb_we   = 1'b0;
    wb_idx  = '0;
    wb_ch   = byte_i;
    op_k    = '0;

    if (nl && (pnl_q != 8'd0) && (byte_i != pnl_q)) begin
      // Absorb the second half of a CR/LF or LF/CR pair
      if ((mode_q == M_LSTR_BODY) && (tl_q == 16'd0) && (ts_q == pos)) begin
        ts_d = pos1;
      end
      pnl_d = 8'd0;
    end else begin
      case (mode_q)
        M_MINUS: begin
          if (byte_i == "-") begin
            mode_d = M_CMT_START;
          end else begin
            p_en = 1'b1;
            p_res = mk(K_MINUS, 8'd0, 16'(ts_q), 16'd0, 16'(line_q), E_NONE);
            mode_d = M_IDLE;
            rs = 1'b1;
          end
        end
        M_CMT_START: begin
          if (byte_i == "[") begin
            mode_d = M_CMT_BRK;
            ol_d = '0;
          end else begin
            do_scmt = 1'b1;
          end
        end
        M_CMT_BRK: begin
          if (byte_i == "=") begin
            ol_d = lvl_inc(ol_q);
          end else if (byte_i == "[") begin
            mode_d = M_CMT_BODY;
          end else begin
            do_scmt = 1'b1;
          end
        end
        M_CMT_SHORT: do_scmt = 1'b1;
        M_CMT_BODY: do_body = 1'b1;
        M_CMT_CLOSE: do_close = 1'b1;
        M_BRK: begin
          if (byte_i == "=") begin
            ol_d = lvl_inc(ol_q);
          end else if (byte_i == "[") begin
            mode_d = M_LSTR_FIRST;
            ts_d = pos1;
            tl_d = 16'd0;
          end else begin
            p_en = 1'b1;
            if (ol_q == '0) begin
              p_res = mk(K_LBRACKET, 8'd0, 16'(ts_q), 16'd0, 16'(line_q), E_NONE);
            end else begin
              p_res = mk(K_STRING, 8'd0, 16'(ts_q), 16'd0, 16'(line_q), E_DELIM);
            end
            mode_d = M_IDLE;
            rs = 1'b1;
          end
        end
        M_LSTR_FIRST: begin
          keep = 1'b1;
          if (nl) begin
            ts_d = pos1;
            mode_d = M_LSTR_BODY;
          end else begin
            do_body = 1'b1;
          end
        end
        M_LSTR_BODY: begin
          keep = 1'b1;
          do_body = 1'b1;
        end
        M_LSTR_CLOSE: begin
          keep = 1'b1;
          do_close = 1'b1;
        end
        M_EQ, M_LT, M_GT, M_TILDE: begin
          mode_d = M_IDLE;
          p_en = 1'b1;
          if (byte_i == "=") begin
            case (mode_q)
              M_EQ:    op_k = K_EQ;
              M_LT:    op_k = K_LE;
              M_GT:    op_k = K_GE;
              default: op_k = K_NE;
            endcase
            p_res = mk(op_k, 8'd0, 16'(ts_q), 16'd0, 16'(line_q), E_NONE);
          end else begin
            rs = 1'b1;
            case (mode_q)
              M_EQ:    op_k = K_SET;
              M_LT:    op_k = K_LT;
              M_GT:    op_k = K_GT;
              default: op_k = K_OTHER;
            endcase
            p_res = mk(op_k, (op_k == K_OTHER) ? 8'("~") : 8'd0, 16'(ts_q), 16'd0,
                       16'(line_q), E_NONE);
          end
        end
        M_STR: do_str = 1'b1;
        M_SESC: begin
          mode_d = M_STR;
          if (byte_i == 8'd0) begin
            p_en = 1'b1;
            p_res = mk(K_STRING, 8'd0, 16'(ts_q), tl_q, 16'(line_q), E_STRING);
            mode_d = M_IDLE;
            rs = 1'b1;
          end else if (is_digit(byte_i)) begin
            ed_d = 2'd1;
            mode_d = M_SDEC;
          end else begin
            tl_d = add_sat(tl_q, 17'd1);
          end
        end
        M_SDEC: begin
          if (is_digit(byte_i) && (ed_q < 2'd3)) begin
            ed_d = ed_q + 2'd1;
            if (ed_q == 2'd2) begin
              tl_d = add_sat(tl_q, 17'd1);
              ed_d = 2'd0;
              mode_d = M_STR;
            end
          end else begin
            tl_d = add_sat(tl_q, 17'd1);
            ed_d = 2'd0;
            mode_d = M_STR;
            do_str = 1'b1;
          end
        end
        M_DOT: begin
          if (byte_i == ".") begin
            mode_d = M_DOT2;
          end else if (is_digit(byte_i)) begin
            mode_d = M_NUM;
            tl_d = 16'd2;
          end else begin
            p_en = 1'b1;
            p_res = mk(K_DOT, 8'd0, 16'(ts_q), 16'd0, 16'(line_q), E_NONE);
            mode_d = M_IDLE;
            rs = 1'b1;
          end
        end
        M_DOT2: begin
          mode_d = M_IDLE;
          p_en = 1'b1;
          if (byte_i == ".") begin
            p_res = mk(K_DOTS, 8'd0, 16'(ts_q), 16'd0, 16'(line_q), E_NONE);
          end else begin
            p_res = mk(K_CONCAT, 8'd0, 16'(ts_q), 16'd0, 16'(line_q), E_NONE);
            rs = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(byte_i) || (byte_i == ".")) begin
            tl_d = add_sat(tl_q, 17'd1);
          end else if ((byte_i == "e") || (byte_i == "E")) begin
            tl_d = add_sat(tl_q, 17'd1);
            mode_d = M_NUMEXP;
          end else if (is_word(byte_i)) begin
            tl_d = add_sat(tl_q, 17'd1);
            mode_d = M_NUMTAIL;
          end else begin
            p_en = 1'b1;
            p_res = mk(K_NUMBER, 8'd0, 16'(ts_q), tl_q, 16'(line_q), E_NONE);
            mode_d = M_IDLE;
            rs = 1'b1;
          end
        end
        M_NUMEXP: begin
          if ((byte_i == "+") || (byte_i == "-") || is_word(byte_i)) begin
            tl_d = add_sat(tl_q, 17'd1);
            mode_d = M_NUMTAIL;
          end else begin
            p_en = 1'b1;
            p_res = mk(K_NUMBER, 8'd0, 16'(ts_q), tl_q, 16'(line_q), E_NONE);
            mode_d = M_IDLE;
            rs = 1'b1;
          end
        end
        M_NUMTAIL: begin
          if (is_word(byte_i)) begin
            tl_d = add_sat(tl_q, 17'd1);
          end else begin
            p_en = 1'b1;
            p_res = mk(K_NUMBER, 8'd0, 16'(ts_q), tl_q, 16'(line_q), E_NONE);
            mode_d = M_IDLE;
            rs = 1'b1;
          end
        end
        M_NAME: begin
          if (is_word(byte_i)) begin
            if (tl_q < 16'(WORD_CHARS)) begin
              wb_we = 1'b1;
              wb_idx = tl_q[IdxBits-1:0];
            end
            tl_d = add_sat(tl_q, 17'd1);
          end else begin
            p_en = 1'b1;
            p_res = mk((tl_q > 16'(KW_CHARS)) ? K_NAME : kw_kind(word, tl_q), 8'd0,
                       16'(ts_q), tl_q, 16'(line_q), E_NONE);
            mode_d = M_IDLE;
            rs = 1'b1;
          end
        end
        default: begin
          mode_d = M_IDLE;
          rs = 1'b1;
        end
      endcase

      // Closing bracket run of a long string or comment
      if (do_close) begin
        if (byte_i == "=") begin
          cl_d = lvl_inc(cl_q);
        end else if (byte_i == "]") begin
          if (cl_q == ol_q) begin
            if (keep) begin
              p_en = 1'b1;
              p_res = mk(K_STRING, 8'd0, 16'(ts_q), tl_q, 16'(line_q), E_NONE);
            end
            mode_d = M_IDLE;
          end else begin
            if (keep) begin
              tl_d = add_sat(tl_q, 17'(cl_q) + 17'd1);
            end
            cl_d = '0;
          end
        end else begin
          if (keep) begin
            tl_d = add_sat(tl_q, 17'(cl_q) + 17'd1);
          end
          do_body = 1'b1;
        end
      end

      // Body byte of a long string or comment
      if (do_body) begin
        mode_d = keep ? M_LSTR_BODY : M_CMT_BODY;
        if (byte_i == 8'd0) begin
          mode_d = M_IDLE;
          p_en = 1'b1;
          if (keep) begin
            p_res = mk(K_STRING, 8'd0, 16'(ts_q), tl_d, 16'(line_q), E_LONG);
            rs = 1'b1;
          end else begin
            p_res = mk(K_END, 8'd0, 16'(pos), 16'd0, 16'(line_q), E_LONG);
          end
        end else if (byte_i == "]") begin
          mode_d = keep ? M_LSTR_CLOSE : M_CMT_CLOSE;
          cl_d = '0;
        end else if (keep) begin
          tl_d = add_sat(tl_d, 17'd1);
        end
      end

      // Short string content byte
      if (do_str) begin
        if (byte_i == qc_q) begin
          p_en = 1'b1;
          p_res = mk(K_STRING, 8'd0, 16'(ts_q), tl_d, 16'(line_q), E_NONE);
          mode_d = M_IDLE;
        end else if ((byte_i == 8'd0) || nl) begin
          p_en = 1'b1;
          p_res = mk(K_STRING, 8'd0, 16'(ts_q), tl_d, 16'(line_q), E_STRING);
          mode_d = M_IDLE;
          rs = 1'b1;
        end else if (byte_i == "\\") begin
          mode_d = M_SESC;
        end else begin
          tl_d = add_sat(tl_d, 17'd1);
        end
      end

      // Short comment byte
      if (do_scmt) begin
        mode_d = M_CMT_SHORT;
        if ((byte_i == 8'd0) || nl) begin
          mode_d = M_IDLE;
          rs = 1'b1;
        end
      end

      // Rescan the byte as the start of a new token
      if (rs) begin
        ts_d = pos;
        tl_d = 16'd0;
        op_k = '0;
        case (byte_i)
          "+":       op_k = K_PLUS;
          "*":       op_k = K_TIMES;
          "/", "\\": op_k = K_DIVIDE;
          "%":       op_k = K_MOD;
          "^":       op_k = K_POW;
          "#":       op_k = K_HASH;
          "(":       op_k = K_LPAREN;
          ")":       op_k = K_RPAREN;
          "{":       op_k = K_LBRACE;
          "}":       op_k = K_RBRACE;
          "]":       op_k = K_RBRACKET;
          ";":       op_k = K_SEMI;
          ":":       op_k = K_COLON;
          ",":       op_k = K_COMMA;
          default:   op_k = '0;
        endcase
        if (nl || (byte_i == " ") || (byte_i == 8'h09) || (byte_i == 8'h0B) ||
            (byte_i == 8'h0C)) begin
          // skip whitespace
        end else if (byte_i == 8'd0) begin
          i_en = 1'b1;
          i_res = mk(K_END, 8'd0, 16'(pos), 16'd0, 16'(line_q), E_NONE);
        end else if (byte_i == "-") begin
          mode_d = M_MINUS;
        end else if (byte_i == "[") begin
          mode_d = M_BRK;
          ol_d = '0;
        end else if (byte_i == "=") begin
          mode_d = M_EQ;
        end else if (byte_i == "<") begin
          mode_d = M_LT;
        end else if (byte_i == ">") begin
          mode_d = M_GT;
        end else if (byte_i == "~") begin
          mode_d = M_TILDE;
        end else if (byte_i == ".") begin
          mode_d = M_DOT;
        end else if ((byte_i == "\"") || (byte_i == "'")) begin
          mode_d = M_STR;
          qc_d = byte_i;
          ts_d = pos1;
        end else if (op_k != 6'd0) begin
          i_en = 1'b1;
          i_res = mk(op_k, 8'd0, 16'(pos), 16'd0, 16'(line_q), E_NONE);
        end else if (is_digit(byte_i)) begin
          mode_d = M_NUM;
          tl_d = 16'd1;
        end else if (is_alpha(byte_i) || (byte_i == "_")) begin
          mode_d = M_NAME;
          tl_d = 16'd1;
          wb_we = 1'b1;
          wb_idx = '0;
        end else begin
          i_en = 1'b1;
          i_res = mk(K_OTHER, byte_i, 16'(pos), 16'd0, 16'(line_q), E_NONE);
        end
      end

      // Count the line end after the tokens it closes
      if (nl) begin
        if (line_q != '1) begin
          line_d = line_q + LINE_BITS'(1);
        end
        pnl_d = byte_i;
      end else begin
        pnl_d = 8'd0;
      end
    end
  end

  // Order the pending token ahead of the rescanned one and mark the last
  always_comb begin
    res0_o = p_en ? p_res : i_res;
    res1_o = i_res;
    res0_o.last = !(p_en && i_en);
    res1_o.last = 1'b1;
    count_o = {1'b0, p_en} + {1'b0, i_en};
  end

  // Advance scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      off_q  <= '0;
      line_q <= LINE_BITS'(1);
      ts_q   <= '0;
      tl_q   <= '0;
      pnl_q  <= '0;
      ol_q   <= '0;
      cl_q   <= '0;
      qc_q   <= '0;
      ed_q   <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      off_q  <= off_d;
      line_q <= line_d;
      ts_q   <= ts_d;
      tl_q   <= tl_d;
      pnl_q  <= pnl_d;
      ol_q   <= ol_d;
      cl_q   <= cl_d;
      qc_q   <= qc_d;
      ed_q   <= ed_d;
    end
  end

  // Word buffer for keyword matching
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WORD_CHARS; i++) begin
        wb_q[i] <= '0;
      end
    end else if (step_i && wb_we) begin
      for (int i = 0; i < WORD_CHARS; i++) begin
        if (wb_idx == IdxBits'(i)) begin
          wb_q[i] <= wb_ch;
        end
      end
    end
  end

endmodule

@@ design/sst_obuf.sv @@
// Two-entry result buffer that hands tokens out one transaction at a time.
// Depends on sst_pkg.
module sst_obuf import sst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [1:0] count_i,
  input  sst_res_t   res0_i,
  input  sst_res_t   res1_i,
  input  logic       ready_i,
  output logic       valid_o,
  output logic [1:0] count_o,
  output sst_res_t   head_o
);

  logic [1:0] cnt_q, cnt_d;
  sst_res_t   s0_q, s0_d, s1_q, s1_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign count_o = cnt_q;
  assign head_o  = s0_q;
  assign pop     = valid_o && ready_i;

  // Load a fresh pair or shift the second token forward
  always_comb begin
    cnt_d = cnt_q;
    s0_d  = s0_q;
    s1_d  = s1_q;
    if (push_i) begin
      cnt_d = count_i;
      s0_d  = res0_i;
      s1_d  = res1_i;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      s0_d  = s1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

endmodule

@@ design/script_source_tokenizer.sv @@
// Top level of the streaming script source tokenizer: input register, scanner, result buffer.
// Depends on sst_pkg, sst_core and sst_obuf.
//
//   channel  | direction | handshake                      | payload
//   source   | in        | source_valid_i/source_ready_o  | source_byte_i
//   token    | out       | token_valid_o/token_ready_i    | token_kind_o ... last_of_run_o
//
// One byte is scanned per cycle while the result buffer can take its tokens, in a single
// pass from the input register to the result buffer; a byte gives zero, one or two tokens.
// A byte giving two tokens occupies the result buffer for two output transactions before
// the next byte is scanned. Reset returns the scanner to idle, offset 0 and line 1 at once;
// no clearing pass. A byte's tokens pass through the input register and the result buffer.
module script_source_tokenizer import sst_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16,
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned WORD_CHARS  = 8,
  parameter int unsigned LEVEL_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        source_valid_i,
  output logic        source_ready_o,
  input  logic [7:0]  source_byte_i,
  output logic        token_valid_o,
  input  logic        token_ready_i,
  output logic [5:0]  token_kind_o,
  output logic [7:0]  raw_char_o,
  output logic [15:0] span_start_o,
  output logic [15:0] span_length_o,
  output logic [15:0] line_count_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);

  logic       in_v_q;
  logic [7:0] byte_q;
  logic       step;
  logic [1:0] buf_cnt, res_cnt;
  sst_res_t   res0, res1, head;

  // Scan when the buffer is empty, or drains its last token this cycle
  assign step = in_v_q && ((buf_cnt == 2'd0) || ((buf_cnt == 2'd1) && token_ready_i));
  assign source_ready_o = !in_v_q || step;

  // Hold the accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (source_ready_o) begin
      in_v_q <= source_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (source_ready_o && source_valid_i) begin
      byte_q <= source_byte_i;
    end
  end

  sst_core #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS),
    .WORD_CHARS  (WORD_CHARS),
    .LEVEL_BITS  (LEVEL_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (byte_q),
    .res0_o  (res0),
    .res1_o  (res1),
    .count_o (res_cnt)
  );

  sst_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .count_i (res_cnt),
    .res0_i  (res0),
    .res1_i  (res1),
    .ready_i (token_ready_i),
    .valid_o (token_valid_o),
    .count_o (buf_cnt),
    .head_o  (head)
  );

  assign token_kind_o  = head.kind;
  assign raw_char_o    = head.raw;
  assign span_start_o  = head.start;
  assign span_length_o = head.len;
  assign line_count_o  = head.line;
  assign error_code_o  = head.err;
  assign last_of_run_o = head.last;

endmodule

@@ test/script_source_tokenizer_tb.sv @@
// Self-checking testbench for script_source_tokenizer: streams source text, predicts tokens.
// Depends on sst_pkg for token kinds, error codes, scan modes and the result struct.

module script_source_tokenizer_tb;
  import sst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_GOAL   = 1500;
  localparam int unsigned TAIL_ITEMS  = 150;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam logic [7:0]  CH_LF       = 8'h0A;
  localparam logic [7:0]  CH_CR       = 8'h0D;

  // Token predictor and store of expected tokens
  class token_scoreboard;
    sst_res_t    tokens_due[$];
    int unsigned mismatches;
    string       kw_words [21];

    sst_mode_e   mode;
    logic [15:0] offset, line_no, tok_start, tok_len;
    logic [7:0]  prev_nl, open_lvl, close_lvl, quote;
    logic [9:0]  esc_val;
    logic [1:0]  esc_digits;
    logic [7:0]  word [8];
    logic [15:0] cur_pos;
    int unsigned step_count;

    function new();
      kw_words = '{"and", "break", "do", "elseif", "else", "end", "false", "for",
                   "function", "if", "in", "local", "nil", "not", "or", "repeat",
                   "return", "then", "true", "until", "while"};
      mismatches = 0;
      mode = M_IDLE; offset = '0; line_no = 16'd1; tok_start = '0; tok_len = '0;
      prev_nl = '0; open_lvl = '0; close_lvl = '0; quote = '0;
      esc_val = '0; esc_digits = '0;
      foreach (word[i]) word[i] = '0;
    endfunction

    function bit digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction
    function bit alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction
    function bit wordch(logic [7:0] b);
      return alpha(b) || digit(b) || b == "_";
    endfunction
    function bit newline(logic [7:0] b);
      return b == CH_LF || b == CH_CR;
    endfunction

    function void emit(logic [5:0] kind, logic [7:0] raw, logic [15:0] st,
                       logic [15:0] len, logic [1:0] err);
      sst_res_t r;
      if (step_count >= 2) return;
      r.kind = kind; r.raw = raw; r.start = st; r.len = len;
      r.line = line_no; r.err = err; r.last = 1'b0;
      tokens_due.push_back(r);
      step_count++;
    endfunction

    function void grow(int unsigned k);
      tok_len = (int'(tok_len) + k > 65535) ? 16'hFFFF : 16'(int'(tok_len) + k);
    endfunction

    function logic [7:0] lvl_up(logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function logic [5:0] word_kind();
      bit ok;
      if (tok_len > 8) return K_NAME;
      for (int i = 0; i < 21; i++) begin
        ok = (kw_words[i].len() == int'(tok_len));
        for (int j = 0; j < 8 && ok; j++)
          if (j < int'(tok_len) && word[j] != kw_words[i][j]) ok = 0;
        if (ok) return 6'(i);
      end
      return K_NAME;
    endfunction

    // First byte of a token
    function void start_token(logic [7:0] b);
      logic [5:0] k;
      k = '0;
      tok_start = cur_pos;
      tok_len = '0;
      if (newline(b) || b == " " || b == 8'h09 || b == 8'h0B || b == 8'h0C) return;
      case (b)
        8'h00: begin emit(K_END, 0, cur_pos, 0, E_NONE); return; end
        "-": begin mode = M_MINUS; return; end
        "[": begin mode = M_BRK; open_lvl = '0; return; end
        "=": begin mode = M_EQ; return; end
        "<": begin mode = M_LT; return; end
        ">": begin mode = M_GT; return; end
        "~": begin mode = M_TILDE; return; end
        ".": begin mode = M_DOT; return; end
        "\"", "'": begin
          mode = M_STR; quote = b; tok_start = cur_pos + 16'd1; return;
        end
        "+": k = K_PLUS;
        "*": k = K_TIMES;
        "/", "\\": k = K_DIVIDE;
        "%": k = K_MOD;
        "^": k = K_POW;
        "#": k = K_HASH;
        "(": k = K_LPAREN;
        ")": k = K_RPAREN;
        "{": k = K_LBRACE;
        "}": k = K_RBRACE;
        "]": k = K_RBRACKET;
        ";": k = K_SEMI;
        ":": k = K_COLON;
        ",": k = K_COMMA;
        default: ;
      endcase
      if (k != 0) begin emit(k, 0, cur_pos, 0, E_NONE); return; end
      if (digit(b)) begin mode = M_NUM; tok_len = 16'd1; return; end
      if (alpha(b) || b == "_") begin
        mode = M_NAME; tok_len = 16'd1; word[0] = b; return;
      end
      emit(K_OTHER, b, cur_pos, 0, E_NONE);
    endfunction

    function bit quoted(logic [7:0] b);
      if (b == quote) begin
        emit(K_STRING, 0, tok_start, tok_len, E_NONE); mode = M_IDLE; return 0;
      end
      if (b == 0 || newline(b)) begin
        emit(K_STRING, 0, tok_start, tok_len, E_STRING); mode = M_IDLE; return 1;
      end
      if (b == "\\") mode = M_SESC; else grow(1);
      return 0;
    endfunction

    function bit bracket_body(logic [7:0] b, bit keep);
      mode = keep ? M_LSTR_BODY : M_CMT_BODY;
      if (b == 0) begin
        mode = M_IDLE;
        if (keep) begin emit(K_STRING, 0, tok_start, tok_len, E_LONG); return 1; end
        emit(K_END, 0, cur_pos, 0, E_LONG);
        return 0;
      end
      if (b == "]") begin
        mode = keep ? M_LSTR_CLOSE : M_CMT_CLOSE; close_lvl = '0; return 0;
      end
      if (keep) grow(1);
      return 0;
    endfunction

    function bit bracket_close(logic [7:0] b, bit keep);
      if (b == "=") begin close_lvl = lvl_up(close_lvl); return 0; end
      if (b == "]") begin
        if (close_lvl == open_lvl) begin
          if (keep) emit(K_STRING, 0, tok_start, tok_len, E_NONE);
          mode = M_IDLE;
        end else begin
          if (keep) grow(int'(close_lvl) + 1);
          close_lvl = '0;
        end
        return 0;
      end
      if (keep) grow(int'(close_lvl) + 1);
      return bracket_body(b, keep);
    endfunction

    function bit line_comment(logic [7:0] b);
      mode = M_CMT_SHORT;
      if (b == 0 || newline(b)) begin mode = M_IDLE; return 1; end
      return 0;
    endfunction

    function bit pair_op(logic [7:0] b, logic [5:0] one, logic [5:0] two);
      mode = M_IDLE;
      if (b == "=") begin emit(two, 0, tok_start, 0, E_NONE); return 0; end
      if (one == K_OTHER) emit(K_OTHER, "~", tok_start, 0, E_NONE);
      else emit(one, 0, tok_start, 0, E_NONE);
      return 1;
    endfunction

    // Continue the open token; return 1 when the byte must be scanned again
    function bit continue_token(logic [7:0] b);
      case (mode)
        M_MINUS: begin
          if (b == "-") begin mode = M_CMT_START; return 0; end
          emit(K_MINUS, 0, tok_start, 0, E_NONE); mode = M_IDLE; return 1;
        end
        M_CMT_START: begin
          if (b == "[") begin mode = M_CMT_BRK; open_lvl = '0; return 0; end
          return line_comment(b);
        end
        M_CMT_BRK: begin
          if (b == "=") begin open_lvl = lvl_up(open_lvl); return 0; end
          if (b == "[") begin mode = M_CMT_BODY; return 0; end
          return line_comment(b);
        end
        M_CMT_SHORT: return line_comment(b);
        M_CMT_BODY: return bracket_body(b, 0);
        M_CMT_CLOSE: return bracket_close(b, 0);
        M_BRK: begin
          if (b == "=") begin open_lvl = lvl_up(open_lvl); return 0; end
          if (b == "[") begin
            mode = M_LSTR_FIRST; tok_start = cur_pos + 16'd1; tok_len = '0; return 0;
          end
          if (open_lvl == 0) emit(K_LBRACKET, 0, tok_start, 0, E_NONE);
          else emit(K_STRING, 0, tok_start, 0, E_DELIM);
          mode = M_IDLE; return 1;
        end
        M_LSTR_FIRST: begin
          if (newline(b)) begin
            tok_start = cur_pos + 16'd1; mode = M_LSTR_BODY; return 0;
          end
          return bracket_body(b, 1);
        end
        M_LSTR_BODY: return bracket_body(b, 1);
        M_LSTR_CLOSE: return bracket_close(b, 1);
        M_EQ: return pair_op(b, K_SET, K_EQ);
        M_LT: return pair_op(b, K_LT, K_LE);
        M_GT: return pair_op(b, K_GT, K_GE);
        M_TILDE: return pair_op(b, K_OTHER, K_NE);
        M_STR: return quoted(b);
        M_SESC: begin
          mode = M_STR;
          if (b == 0) begin
            emit(K_STRING, 0, tok_start, tok_len, E_STRING); mode = M_IDLE; return 1;
          end
          if (digit(b)) begin
            esc_val = 10'(b - "0"); esc_digits = 2'd1; mode = M_SDEC; return 0;
          end
          grow(1);
          return 0;
        end
        M_SDEC: begin
          if (digit(b) && esc_digits < 3) begin
            esc_val = 10'(esc_val * 10 + (b - "0"));
            esc_digits++;
            if (esc_digits >= 3) begin grow(1); esc_digits = '0; mode = M_STR; end
            return 0;
          end
          grow(1); esc_digits = '0; mode = M_STR;
          return quoted(b);
        end
        M_DOT: begin
          if (b == ".") begin mode = M_DOT2; return 0; end
          if (digit(b)) begin mode = M_NUM; tok_len = 16'd2; return 0; end
          emit(K_DOT, 0, tok_start, 0, E_NONE); mode = M_IDLE; return 1;
        end
        M_DOT2: begin
          mode = M_IDLE;
          if (b == ".") begin emit(K_DOTS, 0, tok_start, 0, E_NONE); return 0; end
          emit(K_CONCAT, 0, tok_start, 0, E_NONE); return 1;
        end
        M_NUM: begin
          if (digit(b) || b == ".") begin grow(1); return 0; end
          if (b == "e" || b == "E") begin grow(1); mode = M_NUMEXP; return 0; end
          if (wordch(b)) begin grow(1); mode = M_NUMTAIL; return 0; end
          emit(K_NUMBER, 0, tok_start, tok_len, E_NONE); mode = M_IDLE; return 1;
        end
        M_NUMEXP: begin
          if (b == "+" || b == "-" || wordch(b)) begin
            grow(1); mode = M_NUMTAIL; return 0;
          end
          emit(K_NUMBER, 0, tok_start, tok_len, E_NONE); mode = M_IDLE; return 1;
        end
        M_NUMTAIL: begin
          if (wordch(b)) begin grow(1); return 0; end
          emit(K_NUMBER, 0, tok_start, tok_len, E_NONE); mode = M_IDLE; return 1;
        end
        M_NAME: begin
          if (wordch(b)) begin
            if (tok_len < 8) word[tok_len[2:0]] = b;
            grow(1);
            return 0;
          end
          emit(word_kind(), 0, tok_start, tok_len, E_NONE); mode = M_IDLE; return 1;
        end
        default: begin mode = M_IDLE; return 1; end
      endcase
    endfunction

    // Note one accepted source byte and queue the tokens it completes
    function void note_byte(logic [7:0] b);
      bit nl;
      nl = newline(b);
      step_count = 0;
      cur_pos = offset;
      offset = offset + 16'd1;
      if (nl && prev_nl != 0 && b != prev_nl) begin
        if (mode == M_LSTR_BODY && tok_len == 0 && tok_start == cur_pos)
          tok_start = cur_pos + 16'd1;
        prev_nl = '0;
        return;
      end
      if (continue_token(b)) start_token(b);
      if (nl) begin
        if (line_no != 16'hFFFF) line_no++;
        prev_nl = b;
      end else begin
        prev_nl = '0;
      end
      if (step_count > 0) tokens_due[tokens_due.size() - 1].last = 1'b1;
    endfunction

    // Compare one delivered token with the oldest expected one
    function void check_token(sst_res_t got);
      sst_res_t want;
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token: %p", got);
        return;
      end
      want = tokens_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("token mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        source_valid_i = 1'b0;
  logic        source_ready_o;
  logic [7:0]  source_byte_i = '0;
  logic        token_valid_o;
  logic        token_ready_i = 1'b0;
  sst_res_t    token_out;

  token_scoreboard sb = new();
  logic [7:0]  source_text[$];
  bit          tail_phase = 0;
  bit          hold_request = 0;
  int unsigned quiet_cycles = 0;

  script_source_tokenizer dut (
    .clk_i, .rst_ni,
    .source_valid_i, .source_ready_o, .source_byte_i,
    .token_valid_o, .token_ready_i,
    .token_kind_o  (token_out.kind),
    .raw_char_o    (token_out.raw),
    .span_start_o  (token_out.start),
    .span_length_o (token_out.len),
    .line_count_o  (token_out.line),
    .error_code_o  (token_out.err),
    .last_of_run_o (token_out.last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Observe transactions on both channels; watchdog on lack of progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (source_valid_i && source_ready_o) sb.note_byte(source_byte_i);
      if (token_valid_o && token_ready_i) sb.check_token(token_out);
      if ((source_valid_i && source_ready_o) || (token_valid_o && token_ready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Token receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    token_ready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        token_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 0;
        token_ready_i <= 1'b1;
      end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
        token_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        token_ready_i <= 1'b1;
      end
    end
  end

  function automatic void add_text(string s);
    foreach (s[i]) source_text.push_back(s[i]);
  endfunction

  function automatic void add_random_chars(int unsigned n, logic [7:0] lo, logic [7:0] hi);
    repeat (n) source_text.push_back(8'($urandom_range(lo, hi)));
  endfunction

  // Append one source fragment: mostly well-formed tokens, some noise and broken ones
  function automatic void add_fragment();
    string ops [] = '{"+", "-", "*", "/", "\\", "%", "^", "#", "==", "~=", "<=", ">=",
                      "<", ">", "=", "(", ")", "{", "}", "[", "]", ";", ":", ",",
                      ".", "..", "...", "~x", "[=", "<x"};
    int unsigned lvl;
    logic [7:0] q;
    case ($urandom_range(0, 11))
      0: add_text(sb.kw_words[$urandom_range(0, 20)]);
      1: begin
        source_text.push_back($urandom_range(0, 1) ? "_" : 8'($urandom_range("a", "z")));
        repeat ($urandom_range(0, 11))
          case ($urandom_range(0, 2))
            0: source_text.push_back(8'($urandom_range("a", "z")));
            1: source_text.push_back(8'($urandom_range("A", "Z")));
            default: source_text.push_back(8'($urandom_range("0", "9")));
          endcase
      end
      2: begin
        if ($urandom_range(0, 3) == 0) add_text(".");
        add_random_chars($urandom_range(1, 4), "0", "9");
        case ($urandom_range(0, 4))
          0: add_text("e+7");
          1: add_text("E");
          2: add_text(".25e-1");
          3: add_text("x1F");
          default: ;
        endcase
      end
      3: begin
        q = $urandom_range(0, 1) ? "\"" : "'";
        source_text.push_back(q);
        repeat ($urandom_range(0, 8))
          case ($urandom_range(0, 5))
            0: add_text("\\n");
            1: begin add_text("\\"); add_random_chars($urandom_range(1, 4), "0", "9"); end
            2: add_text($urandom_range(0, 1) ? "\\\"" : "\\'");
            3: source_text.push_back(q ^ 8'h05);
            default: add_random_chars(1, " ", "z");
          endcase
        if ($urandom_range(0, 7) == 0) source_text.push_back(CH_LF);
        else source_text.push_back(q);
      end
      4: begin
        if ($urandom_range(0, 1)) add_text("--");
        lvl = $urandom_range(0, 2);
        add_text("[");
        repeat (lvl) add_text("=");
        add_text("[");
        if ($urandom_range(0, 1)) source_text.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
        if ($urandom_range(0, 1)) begin
          source_text.push_back(CH_CR); source_text.push_back(CH_LF);
        end
        add_random_chars($urandom_range(0, 6), " ", "~");
        add_text("]");
        repeat ($urandom_range(0, 3)) add_text("=");
        add_text("]x]");
        repeat (lvl) add_text("=");
        add_text("]");
      end
      5: begin
        add_text("--");
        add_random_chars($urandom_range(0, 6), " ", "~");
        source_text.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
      end
      6, 7: add_text(ops[$urandom_range(0, ops.size() - 1)]);
      8: begin
        source_text.push_back(CH_CR);
        if ($urandom_range(0, 1)) source_text.push_back(CH_LF);
        if ($urandom_range(0, 2) == 0) source_text.push_back(CH_CR);
      end
      9: add_random_chars($urandom_range(1, 3), 0, 255);
      10: source_text.push_back(8'h00);
      default: add_text(" ");
    endcase
    if ($urandom_range(0, 1)) source_text.push_back($urandom_range(0, 4) == 0 ? 8'h09 : " ");
  endfunction

  // Source sender
  initial begin
    int unsigned total;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed text: operators, escapes, long brackets, line-end pairs, bad delimiter, end
    add_text("and x.5e+9");
    source_text.push_back(CH_LF); source_text.push_back(CH_CR);
    add_text("'\\65\\n'[=[");
    source_text.push_back(CH_CR); source_text.push_back(CH_LF);
    add_text("]=]~=<=...\"u");
    source_text.push_back(CH_LF);
    add_text("[=x");
    source_text.push_back(8'h00);
    source_text.push_back(8'hFF);
    add_text("'\\");
    source_text.push_back(8'h00);
    add_text("--[[");
    source_text.push_back(8'h00);

    // Saturating bracket level, once
    add_text("[");
    repeat (300) add_text("=");
    add_text("[z]");
    repeat (300) add_text("=");
    add_text("]");

    while (source_text.size() < ITEM_GOAL) add_fragment();
    add_text(" [[q");
    source_text.push_back(8'h00);
    total = source_text.size();

    for (int unsigned i = 0; i < total; i++) begin
      tail_phase = (i + TAIL_ITEMS >= total);
      if (i == total / 3) begin
        // Drain everything before going on
        source_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.tokens_due.size() != 0) @(posedge clk_i);
      end
      if (i == total / 2) hold_request = 1;
      if (!tail_phase && $urandom_range(0, 11) == 0) begin
        source_valid_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      source_valid_i <= 1'b1;
      source_byte_i  <= source_text[i];
      @(posedge clk_i);
      while (!source_ready_o) @(posedge clk_i);
    end
    source_valid_i <= 1'b0;

    @(posedge clk_i);
    while (sb.tokens_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/sst_pkg.sv
design/sst_core.sv
design/sst_obuf.sv
design/script_source_tokenizer.sv
test/script_source_tokenizer_tb.sv
